// ----- rtl/core/lofs_pkg.sv -----
package lofs_pkg;

  // Converter sample width, channel count and field widths
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int NUM_CH          = 8;
  localparam int CH_BITS         = 3;
  localparam int WIN_BITS        = 12;
  localparam int PERIOD_BITS     = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int STATUS_BITS     = 8;

  // Register reset values
  localparam logic [WIN_BITS-1:0]    ELEC_LO_RST   = 12'd1156;
  localparam logic [WIN_BITS-1:0]    ELEC_HI_RST   = 12'd1413;
  localparam logic [WIN_BITS-1:0]    RL_LO_RST     = 12'd1287;
  localparam logic [WIN_BITS-1:0]    RL_HI_RST     = 12'd1573;
  localparam logic [PERIOD_BITS-1:0] SCAN_PER_RST  = 16'd100;
  localparam logic [PERIOD_BITS-1:0] EVAL_PER_RST  = 16'd500;

  // Channel that uses the right-leg window
  localparam int CH_RL        = 1;
  // Channels at or above this index are overload inputs, never evaluated
  localparam int CH_OVERLOAD  = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ELEC_LO  = 3'd0,
    REG_ELEC_HI  = 3'd1,
    REG_RL_LO    = 3'd2,
    REG_RL_HI    = 3'd3,
    REG_SCAN_PER = 3'd4,
    REG_EVAL_PER = 3'd5
  } cfg_reg_t;

  // Window bounds handed to the evaluator
  typedef struct packed {
    logic [WIN_BITS-1:0] elec_lo;
    logic [WIN_BITS-1:0] elec_hi;
    logic [WIN_BITS-1:0] rl_lo;
    logic [WIN_BITS-1:0] rl_hi;
  } win_cfg_t;

  // Scheduler result for one tick
  typedef struct packed {
    logic               scan_fire;
    logic               eval_fire;
    logic [CH_BITS-1:0] channel;
  } sched_t;

endpackage

// ----- rtl/core/lofs_sched.sv -----
module lofs_sched #(
  parameter int SAMPLE_BITS = lofs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           step,
  input  logic [SAMPLE_BITS-1:0]                         sample,
  input  logic [lofs_pkg::PERIOD_BITS-1:0]               scan_period,
  input  logic [lofs_pkg::PERIOD_BITS-1:0]               eval_period,
  output lofs_pkg::sched_t                               sched,
  output logic [lofs_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]   values_nxt
);
  import lofs_pkg::*;

  logic [CH_BITS-1:0]                     channel_r, channel_nxt;
  logic [PERIOD_BITS-1:0]                 scan_cnt_r, scan_cnt_nxt;
  logic [PERIOD_BITS-1:0]                 eval_cnt_r, eval_cnt_nxt;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]     values_r;
  logic                                   scan_fire;
  logic                                   eval_fire;

  assign scan_fire = (scan_cnt_r == '0);
  assign eval_fire = (eval_cnt_r == '0);

  // Store the sample and advance the mux on a scan event; reload or count down
  always_comb begin
    values_nxt   = values_r;
    channel_nxt  = channel_r;
    scan_cnt_nxt = scan_cnt_r - 1'b1;
    eval_cnt_nxt = eval_cnt_r - 1'b1;
    if (scan_fire) begin
      values_nxt[channel_r] = sample;
      channel_nxt           = channel_r + 1'b1;
      scan_cnt_nxt          = (scan_period == '0) ? '0 : scan_period - 1'b1;
    end
    if (eval_fire) begin
      eval_cnt_nxt = (eval_period == '0) ? '0 : eval_period - 1'b1;
    end
  end

  assign sched.scan_fire = scan_fire;
  assign sched.eval_fire = eval_fire;
  assign sched.channel   = channel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      values_r   <= '0;
      channel_r  <= '0;
      scan_cnt_r <= '0;
      eval_cnt_r <= '0;
    end else if (step) begin
      values_r   <= values_nxt;
      channel_r  <= channel_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      eval_cnt_r <= eval_cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A scan event advances the mux by exactly one channel
  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && scan_fire |=> channel_r == $past(channel_r) + 1'b1)
    else $error("mux select did not advance on scan event");

  // Without a scan event the mux select holds
  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !scan_fire |=> channel_r == $past(channel_r))
    else $error("mux select moved without scan event");
`endif

endmodule

// ----- rtl/core/lofs_eval.sv -----
module lofs_eval #(
  parameter int SAMPLE_BITS = lofs_pkg::SAMPLE_BITS_DEF
) (
  input  logic [lofs_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0] values,
  input  lofs_pkg::win_cfg_t                           win,
  output logic [lofs_pkg::STATUS_BITS-1:0]             status
);
  import lofs_pkg::*;

  localparam int CMP_BITS = (SAMPLE_BITS > WIN_BITS) ? SAMPLE_BITS : WIN_BITS;

  logic [CMP_BITS-1:0] elec_lo_x, elec_hi_x, rl_lo_x, rl_hi_x;

  assign elec_lo_x = CMP_BITS'(win.elec_lo);
  assign elec_hi_x = CMP_BITS'(win.elec_hi);
  assign rl_lo_x   = CMP_BITS'(win.rl_lo);
  assign rl_hi_x   = CMP_BITS'(win.rl_hi);

  // Clear a lead's alarm bit when its value lies strictly inside its window
  always_comb begin
    logic [CMP_BITS-1:0] v;
    status = '1;
    for (int i = 0; i < CH_OVERLOAD; i++) begin
      v = CMP_BITS'(values[i]);
      if (i == CH_RL) begin
        if ((v > rl_lo_x) && (v < rl_hi_x)) status[i] = 1'b0;
      end else begin
        if ((v > elec_lo_x) && (v < elec_hi_x)) status[i] = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/lead_off_scan_window_check.sv -----
// Lead-off scan and window check.
// Input channel (in_valid/in_ready/in_adc_sample): one transfer per timebase
// tick, carrying the converter reading of the mux output. Every transfer
// yields exactly one result on the output channel (out_valid/out_ready):
// the mux select after the tick, the lead status byte and a flag that marks
// the ticks on which the status was rebuilt.
// A tick's result is registered and presented from the cycle after the tick is
// accepted. The block takes one tick per cycle while the receiver keeps up; the
// work is a countdown pair, one sample store and parallel window compares, all
// between the input transfer and the result register.
// When the receiver stalls, the result is held and in_ready drops, so the
// input waits; in_ready is high whenever the result register is empty or is
// being emptied in the same cycle.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// unknown indexes are ignored. Write it only while no tick is in flight.
// Reset (rst_n low, synchronous) loads the default windows and periods,
// clears the sample store, the mux select and the status byte, and arms
// both scan and evaluation to fire on the first tick.
module lead_off_scan_window_check #(
  parameter int SAMPLE_BITS = lofs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [SAMPLE_BITS-1:0]                  in_adc_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [lofs_pkg::CH_BITS-1:0]            out_mux_select,
  output logic [lofs_pkg::STATUS_BITS-1:0]        out_lead_status,
  output logic                                    out_status_updated,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lofs_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lofs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import lofs_pkg::*;

  win_cfg_t                            win_r;
  logic [PERIOD_BITS-1:0]              scan_per_r;
  logic [PERIOD_BITS-1:0]              eval_per_r;
  logic                                in_xfer;
  sched_t                              sched;
  logic [NUM_CH-1:0][SAMPLE_BITS-1:0]  values_nxt;
  logic [STATUS_BITS-1:0]              eval_status;
  logic [STATUS_BITS-1:0]              status_r, status_nxt;
  logic                                out_valid_r;
  logic [CH_BITS-1:0]                  mux_r;
  logic                                updated_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.elec_lo <= ELEC_LO_RST;
      win_r.elec_hi <= ELEC_HI_RST;
      win_r.rl_lo   <= RL_LO_RST;
      win_r.rl_hi   <= RL_HI_RST;
      scan_per_r    <= SCAN_PER_RST;
      eval_per_r    <= EVAL_PER_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ELEC_LO:  win_r.elec_lo <= cfg_data[WIN_BITS-1:0];
        REG_ELEC_HI:  win_r.elec_hi <= cfg_data[WIN_BITS-1:0];
        REG_RL_LO:    win_r.rl_lo   <= cfg_data[WIN_BITS-1:0];
        REG_RL_HI:    win_r.rl_hi   <= cfg_data[WIN_BITS-1:0];
        REG_SCAN_PER: scan_per_r    <= cfg_data[PERIOD_BITS-1:0];
        REG_EVAL_PER: eval_per_r    <= cfg_data[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  lofs_sched #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .sample      (in_adc_sample),
    .scan_period (scan_per_r),
    .eval_period (eval_per_r),
    .sched       (sched),
    .values_nxt  (values_nxt)
  );

  lofs_eval #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .values (values_nxt),
    .win    (win_r),
    .status (eval_status)
  );

  // Rebuild the status byte on an evaluation event, otherwise hold it
  assign status_nxt = sched.eval_fire ? eval_status : status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mux_r     <= sched.channel;
      updated_r <= sched.eval_fire;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mux_select     = mux_r;
  assign out_lead_status    = status_r;
  assign out_status_updated = updated_r;

`ifndef NO_ASSERTIONS
  // Every accepted tick leaves a result waiting
  a_result_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted tick left no result");

  // Overload bits are always set in a rebuilt status
  a_overload_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && updated_r |-> status_r[STATUS_BITS-1:CH_OVERLOAD] == '1)
    else $error("overload bits cleared in rebuilt status");

  // Status byte changes only on a tick that rebuilds it
  a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !sched.eval_fire |=> status_r == $past(status_r))
    else $error("status byte changed without evaluation event");
`endif

endmodule
